// ===== rtl/core/lmc_pkg.sv =====
// Types, constants and helpers for the line marker classifier.
// No dependencies; used by line_marker_classifier.
`default_nettype none

package lmc_pkg;

    localparam int unsigned SensorW  = 16;
    localparam int unsigned PosW     = 16;
    localparam int unsigned IdxW     = 4;
    localparam int unsigned AccW     = 32;
    localparam int unsigned ShiftW   = 4;
    localparam int unsigned CodeW    = 3;
    localparam int unsigned InDataW  = 40;
    localparam int unsigned OutDataW = 8;

    localparam logic [AccW-1:0] LeftMask  = 32'hFFF8_0000;
    localparam logic [AccW-1:0] RightMask = 32'h0000_0FFF;
    localparam logic [AccW-1:0] FullMask  = 32'h007F_FF00;

    localparam int PosOffset = 32000;
    localparam int PosStep   = 4000;
    localparam int unsigned WideCount = 4;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_MARK     = 2'd1,
        PH_DECISION = 2'd2
    } t_phase;

    typedef enum logic [CodeW-1:0] {
        MC_NONE  = 3'd0,
        MC_LEFT  = 3'd1,
        MC_RIGHT = 3'd2,
        MC_END   = 3'd3,
        MC_CROSS = 3'd4
    } t_mark_code;

    // Alignment shift (pos + 32000) / 4000, found by counting step thresholds passed.
    // Positions from +28000 up land on 15 and those below -28000 on 0, just as after saturation.
    function automatic logic [ShiftW-1:0] align_shift(input logic signed [PosW-1:0] pos);
        logic [ShiftW-1:0] k;
        k = '0;
        for (int i = 1; i < 16; i++) begin
            if (int'(pos) >= i * PosStep - PosOffset) begin
                k = k + ShiftW'(1);
            end
        end
        return k;
    endfunction

    function automatic logic [AccW-1:0] align_sample(input logic signed [PosW-1:0] pos,
                                                     input logic [SensorW-1:0] bits);
        return {{(AccW-SensorW){1'b0}}, bits} << align_shift(pos);
    endfunction

    function automatic logic [4:0] count_ones16(input logic [SensorW-1:0] v);
        logic [4:0] n;
        n = '0;
        for (int i = 0; i < SensorW; i++) begin
            n = n + 5'(v[i]);
        end
        return n;
    endfunction

    // Sensor j sits at bit 15-j; the window covers first..last inclusive.
    function automatic logic [SensorW-1:0] window_mask(input logic [IdxW-1:0] first,
                                                       input logic [IdxW-1:0] last);
        logic [SensorW-1:0] m;
        for (int j = 0; j < SensorW; j++) begin
            m[SensorW-1-j] = (IdxW'(j) >= first) && (IdxW'(j) <= last);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/line_marker_classifier.sv =====
// Line marker classifier: one sensor sample in, one classification word out.
// Depends on lmc_pkg for types, masks and the alignment helpers.
//
// Usage:
//   Slave channel (i_s_axis_*) carries one sensor sample per word. Master
//   channel (o_m_axis_*) returns exactly one result word per sample, in order.
//   A sample is classified in the cycle it is taken and its result sits in the
//   output register from the next cycle. The output register is the only
//   stage; a new word is taken whenever that register is empty or is being
//   emptied in the same cycle, so the rate is one word per clock while the
//   receiver keeps up.
//   When the receiver stalls, the result holds and the input is refused
//   until the held word has been taken; no word is dropped.
//   Reset (i_rst_n low, synchronous) returns the phase to idle, clears the
//   accumulator and both held flags, and empties the output register.
//   mark_code is nonzero only for the word that closes a marker.
`default_nettype none

module line_marker_classifier (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output      logic                              o_s_axis_tready,
    // [15:0] sensor_bits, [31:16] position, [35:32] window_first,
    // [39:36] window_last
    input  wire logic [lmc_pkg::InDataW-1:0]       i_s_axis_tdata,
    output      logic                              o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // [2:0] mark_code, [3] marker_seen, [4] left_flag, [5] right_flag, [7:6] zero
    output      logic [lmc_pkg::OutDataW-1:0]      o_m_axis_tdata
);

    lmc_pkg::t_phase                 r_phase, n_phase;
    logic [lmc_pkg::AccW-1:0]        r_acc, n_acc;
    logic                            r_left_held, n_left_held;
    logic                            r_right_held, n_right_held;
    logic                            r_out_valid;
    logic [lmc_pkg::OutDataW-1:0]    r_out_data;

    logic [lmc_pkg::SensorW-1:0]     sensor_bits;
    logic signed [lmc_pkg::PosW-1:0] position;
    logic [lmc_pkg::IdxW-1:0]        window_first;
    logic [lmc_pkg::IdxW-1:0]        window_last;
    logic [lmc_pkg::SensorW-1:0]     win;
    logic                            marker;
    logic                            wide;
    logic [lmc_pkg::AccW-1:0]        aligned;
    logic                            acc_l, acc_r, acc_full;
    lmc_pkg::t_mark_code             code;
    logic                            s_acc;

    assign sensor_bits  = i_s_axis_tdata[15:0];
    assign position     = i_s_axis_tdata[31:16];
    assign window_first = i_s_axis_tdata[35:32];
    assign window_last  = i_s_axis_tdata[39:36];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    assign win      = lmc_pkg::window_mask(window_first, window_last);
    assign marker   = (sensor_bits & ~win) != '0;
    assign wide     = lmc_pkg::count_ones16(sensor_bits & win) > 5'(lmc_pkg::WideCount);
    assign aligned  = lmc_pkg::align_sample(position, sensor_bits);
    assign acc_l    = (r_acc & lmc_pkg::LeftMask) != '0;
    assign acc_r    = (r_acc & lmc_pkg::RightMask) != '0;
    assign acc_full = (r_acc & lmc_pkg::FullMask) == lmc_pkg::FullMask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= lmc_pkg::PH_IDLE;
            r_acc        <= '0;
            r_left_held  <= 1'b0;
            r_right_held <= 1'b0;
        end else if (s_acc) begin
            r_phase      <= n_phase;
            r_acc        <= n_acc;
            r_left_held  <= n_left_held;
            r_right_held <= n_right_held;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_acc        = r_acc;
        n_left_held  = r_left_held;
        n_right_held = r_right_held;
        code         = lmc_pkg::MC_NONE;
        unique case (r_phase)
            lmc_pkg::PH_MARK: begin
                // flags come from the accumulator before this word is merged
                n_left_held  = acc_l;
                n_right_held = acc_r;
                if (!marker) begin
                    n_phase = lmc_pkg::PH_DECISION;
                end else begin
                    n_acc = r_acc | aligned;
                end
            end
            lmc_pkg::PH_DECISION: begin
                n_phase      = lmc_pkg::PH_IDLE;
                n_left_held  = 1'b0;
                n_right_held = 1'b0;
                if (acc_full) begin
                    code = lmc_pkg::MC_CROSS;
                end else if (acc_l && acc_r) begin
                    code = lmc_pkg::MC_END;
                end else if (acc_l) begin
                    code = lmc_pkg::MC_LEFT;
                end else if (acc_r) begin
                    code = lmc_pkg::MC_RIGHT;
                end
            end
            default: begin
                n_phase = lmc_pkg::PH_IDLE;
                if (wide || marker) begin
                    n_acc   = aligned;
                    n_phase = lmc_pkg::PH_MARK;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_out_data <= {2'b00, n_right_held, n_left_held, marker, code};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTH
    // A decision word always returns the machine to idle.
    a_decision_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && r_phase == lmc_pkg::PH_DECISION) |=> (r_phase == lmc_pkg::PH_IDLE))
        else $error("decision word did not return to idle");

    // Held flags are clear whenever the machine is idle.
    a_idle_flags_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == lmc_pkg::PH_IDLE) |-> (!r_left_held && !r_right_held))
        else $error("held flags set while idle");

    // Every accepted sample leaves a result waiting.
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> r_out_valid)
        else $error("accepted sample left no result");

    // A nonzero mark code only comes from the decision phase.
    a_code_from_decision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && r_phase != lmc_pkg::PH_DECISION)
            |=> (r_out_data[2:0] == lmc_pkg::MC_NONE))
        else $error("mark code outside decision");
`endif

endmodule

`default_nettype wire
